// File: sv/htw_pkg.sv
// Shared types and constants of the hashed timeout wheel.
// No dependencies; compile first.
`default_nettype none

package htw_pkg;

    // Field widths of the transactions
    localparam int TOPIC_W   = 16;
    localparam int TIMEOUT_W = 20;
    localparam int ROUNDS_W  = 15;

    // Rounds counter saturation value
    localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = '1;

    // Results a single tick may emit, and a counter wide enough for them
    localparam int MAX_RESULTS  = 8;
    localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    typedef struct packed {
        op_t                  operation;
        logic [TOPIC_W-1:0]   topic_id;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } request_t;

    typedef struct packed {
        kind_t                kind;
        logic [TOPIC_W-1:0]   expired_topic;
        logic [TIMEOUT_W-1:0] expired_timeout;
        logic                 last;
    } result_t;

    // One stored wheel entry
    typedef struct packed {
        logic [TOPIC_W-1:0]   topic;
        logic [TIMEOUT_W-1:0] timeout;
        logic [ROUNDS_W-1:0]  rounds;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/htw_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set by the instantiating module; no package needed.
`default_nettype none

interface htw_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/htw_div.sv
// Division of a timeout by the wheel size through reciprocal multiplication,
// pipelined as a multiply, an estimate and one correction step. Depends on htw_pkg.
`default_nettype none

module htw_div #(
    parameter int WHEEL_SLOTS = 60
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [htw_pkg::TIMEOUT_W-1:0] dividend,
    output logic                               done,
    output logic [htw_pkg::TIMEOUT_W-1:0]      quotient,
    output logic [$clog2(WHEEL_SLOTS)-1:0]     remainder
);
    import htw_pkg::*;

    localparam int RW = $clog2(WHEEL_SLOTS);
    localparam int PW = 2 * TIMEOUT_W;
    // floor(2^TIMEOUT_W / WHEEL_SLOTS): the estimate is low by at most one
    localparam logic [TIMEOUT_W-1:0] RECIP =
        TIMEOUT_W'((64'd1 << TIMEOUT_W) / 64'(WHEEL_SLOTS));
    localparam logic [TIMEOUT_W-1:0] DIVISOR = TIMEOUT_W'(WHEEL_SLOTS);

    logic [2:0]           stage_reg, stage_next;
    logic                 done_reg, done_next;
    logic [TIMEOUT_W-1:0] x_reg, x_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [TIMEOUT_W-1:0] qe_reg, qe_next;
    logic [TIMEOUT_W-1:0] qd_reg, qd_next;
    logic [TIMEOUT_W-1:0] q_reg, q_next;
    logic [RW-1:0]        r_reg, r_next;
    logic [TIMEOUT_W-1:0] r_est;

    // Multiply by the reciprocal, form the estimate, then correct it once
    always_comb
    begin
        stage_next = {stage_reg[1:0], start};
        done_next  = stage_reg[2];
        x_next     = start ? dividend : x_reg;
        prod_next  = prod_reg;
        qe_next    = qe_reg;
        qd_next    = qd_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        r_est      = x_reg - qd_reg;
        if (stage_reg[0])
            prod_next = PW'(x_reg) * PW'(RECIP);
        if (stage_reg[1])
        begin
            qe_next = prod_reg[PW-1:TIMEOUT_W];
            qd_next = prod_reg[PW-1:TIMEOUT_W] * DIVISOR;
        end
        if (stage_reg[2])
        begin
            if (r_est >= DIVISOR)
            begin
                q_next = qe_reg + 1'b1;
                r_next = RW'(r_est - DIVISOR);
            end
            else
            begin
                q_next = qe_reg;
                r_next = r_est[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            prod_reg  <= '0;
            qe_reg    <= '0;
            qd_reg    <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
            x_reg     <= x_next;
            prod_reg  <= prod_next;
            qe_reg    <= qe_next;
            qd_reg    <= qd_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

// File: sv/htw_fill_ram.sv
// Per-slot fill counts: synchronous RAM with one valid bit per slot,
// so every slot reads as empty straight after reset. Depends on nothing.
`default_nettype none

module htw_fill_ram #(
    parameter int WHEEL_SLOTS = 60,
    parameter int SLOT_DEPTH  = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              we,
    input  wire logic [$clog2(WHEEL_SLOTS)-1:0]    waddr,
    input  wire logic [$clog2(SLOT_DEPTH+1)-1:0]   wdata,
    input  wire logic                              re,
    input  wire logic [$clog2(WHEEL_SLOTS)-1:0]    raddr,
    output logic [$clog2(SLOT_DEPTH+1)-1:0]        rdata
);
    localparam int FW = $clog2(SLOT_DEPTH + 1);

    logic [FW-1:0]          mem [WHEEL_SLOTS];
    logic [WHEEL_SLOTS-1:0] vld_reg;
    logic [FW-1:0]          rd_data_reg;
    logic                   rd_vld_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    // Valid bits cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
                vld_reg[waddr] <= 1'b1;
            if (re)
                rd_vld_reg <= vld_reg[raddr];
        end
    end

    // An unwritten slot reads as empty
    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: sv/htw_entry_ram.sv
// Wheel entry store: one write port, one registered read port.
// Depends on htw_pkg for the entry type.
`default_nettype none

module htw_entry_ram #(
    parameter int WHEEL_SLOTS = 60,
    parameter int SLOT_DEPTH  = 8
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [$clog2(WHEEL_SLOTS*SLOT_DEPTH)-1:0]  waddr,
    input  wire htw_pkg::entry_t                            wdata,
    input  wire logic                                       re,
    input  wire logic [$clog2(WHEEL_SLOTS*SLOT_DEPTH)-1:0]  raddr,
    output htw_pkg::entry_t                                 rdata
);
    import htw_pkg::*;

    localparam int DEPTH = WHEEL_SLOTS * SLOT_DEPTH;

    entry_t mem [DEPTH];
    entry_t rd_reg;

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

`default_nettype wire

// File: sv/hashed_timeout_wheel_top.sv
// Hashed timing wheel with round counters: control sequencer and output stage.
// Depends on htw_pkg, htw_chan_if, htw_div, htw_fill_ram, htw_entry_ram.
//
//   channel   direction  payload      transactions
//   request   sink       request_t    add entry or one tick
//   result    source     result_t     one add ack/reject, or 0..8 expiries per tick
//
// An add holds the request channel while it splits the timeout into slot offset
// and rounds by reciprocal multiplication, reads the slot fill, then appends the
// entry and answers. A tick holds it while it reads the new slot's fill and
// walks the slot, one entry a cycle unless stalled, through the single read
// port of the entry RAM. Reset clears the per-slot valid bits at once; there is
// no clearing pass. A stalled result channel holds the answer and stops the walk.
`default_nettype none

module hashed_timeout_wheel_top #(
    parameter int WHEEL_SLOTS = 60,
    parameter int SLOT_DEPTH  = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    htw_chan_if.sink   request,
    htw_chan_if.source result
);
    import htw_pkg::*;

    localparam int SW = $clog2(WHEEL_SLOTS);
    localparam int FW = $clog2(SLOT_DEPTH + 1);
    localparam int IW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int AW = $clog2(WHEEL_SLOTS * SLOT_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SLOT,
        ST_ADD,
        ST_TFILL,
        ST_WALK,
        ST_TEND
    } state_t;

    state_t              state_reg, state_next;
    logic [SW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       rd_idx_reg, rd_idx_next;
    logic [FW-1:0]       keep_reg, keep_next;
    logic [RESULT_CNT_W-1:0] n_reg, n_next;
    logic                dvalid_reg, dvalid_next;
    logic                pend_valid_reg, pend_valid_next;
    entry_t              pend_reg, pend_next;
    entry_t              add_reg, add_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                 accept;
    logic                 out_free;
    logic                 expire;
    logic                 stall;
    logic [SW-1:0]        tick_slot;
    logic [SW:0]          slot_sum;
    logic [TIMEOUT_W-1:0] q_adj;

    logic                 div_start;
    logic [TIMEOUT_W-1:0] div_dividend;
    logic                 div_done;
    logic [TIMEOUT_W-1:0] div_quot;
    logic [SW-1:0]        div_rem;

    logic                 fill_we, fill_re;
    logic [SW-1:0]        fill_raddr;
    logic [FW-1:0]        fill_wdata, fill_rdata;

    logic                 ent_we, ent_re;
    logic [AW-1:0]        ent_waddr, ent_raddr;
    entry_t               ent_wdata, ent_rdata;

    htw_div #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    htw_fill_ram #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .SLOT_DEPTH  (SLOT_DEPTH)
    ) u_fill_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (fill_we),
        .waddr (slot_reg),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    htw_entry_ram #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .SLOT_DEPTH  (SLOT_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Handshake terms
    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // Next wheel position on a tick
    assign tick_slot = (pos_reg == SW'(WHEEL_SLOTS - 1)) ? '0 : pos_reg + 1'b1;

    // Target slot of an add: position plus remainder, wrapped once
    assign slot_sum = {1'b0, pos_reg} + {1'b0, div_rem};
    assign q_adj    = div_quot - TIMEOUT_W'(div_rem == '0);

    // Expiry decision for the entry on the read port during the walk
    assign expire = (state_reg == ST_WALK) && dvalid_reg && (ent_rdata.rounds == '0)
                    && (n_reg < RESULT_CNT_W'(MAX_RESULTS));
    assign stall  = expire && pend_valid_reg && !out_free;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        base_next       = base_reg;
        fill_next       = fill_reg;
        rd_idx_next     = rd_idx_reg;
        keep_next       = keep_reg;
        n_next          = n_reg;
        dvalid_next     = dvalid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        add_next        = add_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_next        = out_reg;

        div_start    = 1'b0;
        div_dividend = (request.payload.timeout_ticks == '0) ?
                       TIMEOUT_W'(1) : request.payload.timeout_ticks;
        fill_re      = 1'b0;
        fill_raddr   = slot_reg;
        fill_we      = 1'b0;
        fill_wdata   = keep_reg;
        ent_re       = 1'b0;
        ent_raddr    = base_reg + AW'(rd_idx_reg[IW-1:0]);
        ent_we       = 1'b0;
        ent_waddr    = base_reg + AW'(keep_reg[IW-1:0]);
        ent_wdata    = ent_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.payload.operation == OP_ADD)
                    begin
                        // Start the split of the timeout into slot and rounds
                        div_start        = 1'b1;
                        add_next.topic   = request.payload.topic_id;
                        add_next.timeout = request.payload.timeout_ticks;
                        state_next       = ST_DIV;
                    end
                    else
                    begin
                        // Advance the wheel and fetch the new slot's fill
                        pos_next   = tick_slot;
                        slot_next  = tick_slot;
                        fill_re    = 1'b1;
                        fill_raddr = tick_slot;
                        state_next = ST_TFILL;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    if (slot_sum >= (SW + 1)'(WHEEL_SLOTS))
                        slot_next = SW'(slot_sum - (SW + 1)'(WHEEL_SLOTS));
                    else
                        slot_next = slot_sum[SW-1:0];
                    if (q_adj > TIMEOUT_W'(ROUNDS_MAX))
                        add_next.rounds = ROUNDS_MAX;
                    else
                        add_next.rounds = q_adj[ROUNDS_W-1:0];
                    state_next = ST_SLOT;
                end
            end

            ST_SLOT:
            begin
                fill_re    = 1'b1;
                base_next  = AW'(slot_reg) * AW'(SLOT_DEPTH);
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                // Append the entry unless the slot is full; acknowledge either way
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.expired_topic   = add_reg.topic;
                    out_next.expired_timeout = add_reg.timeout;
                    out_next.last            = 1'b1;
                    if (fill_rdata >= FW'(SLOT_DEPTH))
                    begin
                        out_next.kind = KIND_ADD_FULL;
                    end
                    else
                    begin
                        out_next.kind = KIND_ADD_OK;
                        ent_we        = 1'b1;
                        ent_waddr     = base_reg + AW'(fill_rdata[IW-1:0]);
                        ent_wdata     = add_reg;
                        fill_we       = 1'b1;
                        fill_wdata    = fill_rdata + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_TFILL:
            begin
                fill_next       = fill_rdata;
                base_next       = AW'(slot_reg) * AW'(SLOT_DEPTH);
                rd_idx_next     = '0;
                keep_next       = '0;
                n_next          = '0;
                dvalid_next     = 1'b0;
                pend_valid_next = 1'b0;
                state_next      = ST_WALK;
            end

            ST_WALK:
            begin
                if (!stall)
                begin
                    // Handle the entry on the read port
                    if (dvalid_reg)
                    begin
                        if (expire)
                        begin
                            n_next          = n_reg + 1'b1;
                            pend_valid_next = 1'b1;
                            pend_next       = ent_rdata;
                            if (pend_valid_reg)
                            begin
                                out_valid_next           = 1'b1;
                                out_next.kind            = KIND_EXPIRED;
                                out_next.expired_topic   = pend_reg.topic;
                                out_next.expired_timeout = pend_reg.timeout;
                                out_next.last            = 1'b0;
                            end
                        end
                        else
                        begin
                            // Compact the survivor towards the head of the slot
                            ent_we = 1'b1;
                            if (ent_rdata.rounds != '0)
                                ent_wdata.rounds = ent_rdata.rounds - 1'b1;
                            keep_next = keep_reg + 1'b1;
                        end
                    end
                    // Fetch the next entry, read ahead of the write pointer
                    if (rd_idx_reg < fill_reg)
                    begin
                        ent_re      = 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                        dvalid_next = 1'b1;
                    end
                    else
                    begin
                        dvalid_next = 1'b0;
                        if (!dvalid_reg)
                            state_next = ST_TEND;
                    end
                end
            end

            ST_TEND:
            begin
                // Store the new fill and flush the held expiry as the final result
                fill_we = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.kind            = KIND_EXPIRED;
                    out_next.expired_topic   = pend_reg.topic;
                    out_next.expired_timeout = pend_reg.timeout;
                    out_next.last            = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            slot_reg       <= '0;
            base_reg       <= '0;
            fill_reg       <= '0;
            rd_idx_reg     <= '0;
            keep_reg       <= '0;
            n_reg          <= '0;
            dvalid_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            add_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            slot_reg       <= slot_next;
            base_reg       <= base_next;
            fill_reg       <= fill_next;
            rd_idx_reg     <= rd_idx_next;
            keep_reg       <= keep_next;
            n_reg          <= n_next;
            dvalid_reg     <= dvalid_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            add_reg        <= add_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hashed timeout wheel: adds and ticks go in,
// each result is checked against a cycle-free model of the wheel.
// Depends on htw_pkg, htw_chan_if and hashed_timeout_wheel_top.

module testbench;

    import htw_pkg::*;

    localparam int SLOTS       = 60;
    localparam int DEPTH       = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 40;
    localparam int SETTLE      = 60;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    htw_chan_if #(.payload_t(request_t)) request_ch ();
    htw_chan_if #(.payload_t(result_t))  result_ch ();

    hashed_timeout_wheel_top #(
        .WHEEL_SLOTS(SLOTS),
        .SLOT_DEPTH (DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_ch),
        .result (result_ch)
    );

    // Model state of the wheel
    int                   wheel_pos;
    int                   slot_count [SLOTS];
    logic [TOPIC_W-1:0]   held_topic [SLOTS][DEPTH];
    logic [TIMEOUT_W-1:0] held_timeout [SLOTS][DEPTH];
    int                   held_rounds [SLOTS][DEPTH];

    request_t request_backlog [$];
    result_t  wheel_outcomes [$];

    int   requests_queued   = 0;
    int   accepted_requests = 0;
    int   mismatch_count    = 0;
    int   cycle_count       = 0;
    int   seen_adds         = 0;
    int   seen_ticks        = 0;
    int   seen_ok           = 0;
    int   seen_full         = 0;
    int   seen_expired      = 0;
    logic request_fire      = 1'b0;

    // Sender and receiver pacing
    int   gap_left       = 0;
    int   burst_left     = 0;
    int   hold_left      = 0;
    logic long_hold_done = 1'b0;
    logic [7:0] rx_phase = '0;

    // Apply one accepted transaction to the model and queue what it causes
    function automatic void wheel_apply(input request_t rq);
        int      eff;
        int      rem;
        int      rounds;
        int      slot;
        int      fill;
        int      keep;
        int      n;
        result_t res;
        if (rq.operation == OP_ADD)
        begin
            eff    = (rq.timeout_ticks == '0) ? 1 : int'(rq.timeout_ticks);
            rem    = eff % SLOTS;
            rounds = eff / SLOTS;
            if (rem == 0)
                rounds = rounds - 1;
            if (rounds > int'(ROUNDS_MAX))
                rounds = int'(ROUNDS_MAX);
            slot = (wheel_pos + rem) % SLOTS;
            res.expired_topic   = rq.topic_id;
            res.expired_timeout = rq.timeout_ticks;
            res.last            = 1'b1;
            if (slot_count[slot] >= DEPTH)
            begin
                res.kind = KIND_ADD_FULL;
            end
            else
            begin
                held_topic[slot][slot_count[slot]]   = rq.topic_id;
                held_timeout[slot][slot_count[slot]] = rq.timeout_ticks;
                held_rounds[slot][slot_count[slot]]  = rounds;
                slot_count[slot] = slot_count[slot] + 1;
                res.kind = KIND_ADD_OK;
            end
            wheel_outcomes.push_back(res);
        end
        else
        begin
            // Advance, then walk the new slot in insertion order
            slot      = (wheel_pos + 1) % SLOTS;
            wheel_pos = slot;
            fill      = slot_count[slot];
            keep      = 0;
            n         = 0;
            for (int i = 0; i < fill; i++)
            begin
                if (held_rounds[slot][i] == 0 && n < MAX_RESULTS)
                begin
                    res.kind            = KIND_EXPIRED;
                    res.expired_topic   = held_topic[slot][i];
                    res.expired_timeout = held_timeout[slot][i];
                    res.last            = 1'b0;
                    wheel_outcomes.push_back(res);
                    n++;
                end
                else
                begin
                    if (held_rounds[slot][i] != 0)
                        held_rounds[slot][i] = held_rounds[slot][i] - 1;
                    held_topic[slot][keep]   = held_topic[slot][i];
                    held_timeout[slot][keep] = held_timeout[slot][i];
                    held_rounds[slot][keep]  = held_rounds[slot][i];
                    keep++;
                end
            end
            slot_count[slot] = keep;
            if (n > 0)
                wheel_outcomes[$].last = 1'b1;
        end
    endfunction

    // Compare one observed result with the oldest prediction
    task automatic check_result(input result_t got);
        result_t want;
        if (wheel_outcomes.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result: kind=%0d topic=%h timeout=%h last=%b",
                         got.kind, got.expired_topic, got.expired_timeout, got.last);
        end
        else
        begin
            want = wheel_outcomes.pop_front();
            if (got.kind !== want.kind || got.expired_topic !== want.expired_topic ||
                got.expired_timeout !== want.expired_timeout || got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch: expected kind=%0d topic=%h timeout=%h last=%b, got kind=%0d topic=%h timeout=%h last=%b",
                             want.kind, want.expired_topic, want.expired_timeout, want.last,
                             got.kind, got.expired_topic, got.expired_timeout, got.last);
            end
        end
        case (got.kind)
            KIND_ADD_OK:   seen_ok++;
            KIND_ADD_FULL: seen_full++;
            KIND_EXPIRED:  seen_expired++;
            default:       ;
        endcase
    endtask

    function automatic void queue_add(input logic [TOPIC_W-1:0] topic,
                                      input logic [TIMEOUT_W-1:0] timeout);
        request_t rq;
        rq.operation     = OP_ADD;
        rq.topic_id      = topic;
        rq.timeout_ticks = timeout;
        request_backlog.push_back(rq);
        requests_queued++;
    endfunction

    // Tick fields are ignored by the block; fill them with noise anyway
    function automatic void queue_tick();
        request_t rq;
        rq.operation     = OP_TICK;
        rq.topic_id      = TOPIC_W'($urandom);
        rq.timeout_ticks = TIMEOUT_W'($urandom);
        request_backlog.push_back(rq);
        requests_queued++;
    endfunction

    // Hold the sender until everything offered has been answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_requests != requests_queued || wheel_outcomes.size() != 0);
    endtask

    // Clock, reset and initial input levels
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        request_ch.valid   = 1'b0;
        request_ch.payload = '0;
        result_ch.ready    = 1'b0;
        wheel_pos = 0;
        foreach (slot_count[s])
            slot_count[s] = 0;
        fork
            forever #1 clk = ~clk;
            begin
                repeat (9) @(posedge clk);
                @(negedge clk);
                rst_n = 1'b1;
            end
        join_none
    end

    // Sample both channels and update the model
    always @(posedge clk)
    begin : monitor
        request_fire = rst_n && request_ch.valid && request_ch.ready;
        if (request_fire)
        begin
            wheel_apply(request_ch.payload);
            accepted_requests++;
            if (request_ch.payload.operation == OP_ADD)
                seen_adds++;
            else
                seen_ticks++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result(result_ch.payload);
    end

    // Offer backlog items in bursts separated by random gaps
    always @(negedge clk)
    begin : driver
        logic     next_valid;
        request_t next_payload;
        if (rst_n)
        begin
            next_valid   = request_ch.valid;
            next_payload = request_ch.payload;
            if (request_fire || !request_ch.valid)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (request_backlog.size() > 0)
                begin
                    next_payload = request_backlog.pop_front();
                    next_valid   = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            request_ch.valid   <= next_valid;
            request_ch.payload <= next_payload;
        end
    end

    // Receiver: rotating stall pattern, plus one long hold-off
    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            rx_phase <= rx_phase + 8'd1;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && accepted_requests >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_phase[7:6])
                    2'd0:    result_ch.ready <= 1'b1;
                    2'd1:    result_ch.ready <= 1'($urandom_range(0, 1));
                    2'd2:    result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= (rx_phase[2:0] != 3'd0);
                endcase
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d predictions outstanding",
                     cycle_count, wheel_outcomes.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int                   pick;
        int                   burst_n;
        logic [TIMEOUT_W-1:0] tmo;
        @(posedge rst_n);

        // Extremes, rem-zero timeouts, zero timeout and a full slot
        queue_add(16'h0000, 20'd0);
        queue_add(16'hFFFF, 20'd1);
        queue_add(16'h1234, 20'd59);
        queue_add(16'hA5A5, 20'd60);
        queue_add(16'h5A5A, 20'd61);
        queue_add(16'h0F0F, 20'd120);
        queue_add(16'hF0F0, 20'hFFFFF);
        for (int i = 0; i < DEPTH + 1; i++)
            queue_add(16'h0100 + 16'(i), 20'd3);
        queue_tick();
        queue_tick();
        queue_tick();
        wait_drained();

        // Random mix: ticks, short timeouts, same-slot clusters, wide timeouts
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            for (int k = 0; k < 45; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    queue_tick();
                end
                else if (pick < 52)
                begin
                    tmo     = TIMEOUT_W'($urandom_range(0, 90));
                    burst_n = $urandom_range(3, DEPTH + 2);
                    for (int b = 0; b < burst_n; b++)
                        queue_add(TOPIC_W'($urandom), tmo);
                    k = k + burst_n - 1;
                end
                else if (pick < 60)
                begin
                    queue_add(TOPIC_W'($urandom), TIMEOUT_W'($urandom));
                end
                else if (pick < 67)
                begin
                    queue_add(TOPIC_W'($urandom), TIMEOUT_W'(60 * $urandom_range(1, 3)));
                end
                else
                begin
                    queue_add(TOPIC_W'($urandom), TIMEOUT_W'($urandom_range(0, 130)));
                end
            end
            wait_drained();
        end

        // Sweep the wheel so that pending short entries come due
        repeat (40)
            queue_tick();
        wait_drained();
        repeat (SETTLE) @(negedge clk);

        $display("summary: %0d adds and %0d ticks accepted, %0d cycles",
                 seen_adds, seen_ticks, cycle_count);
        $display("summary: %0d adds stored, %0d rejected on full slot, %0d expiries",
                 seen_ok, seen_full, seen_expired);
        if (mismatch_count == 0 && wheel_outcomes.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
